>>> rtl/core/osf_pkg.sv
// Shared types and constants for the outlier limited smoothing filter.
// Used by osf_cfg_regs, osf_core and the top level; depends on nothing.
package osf_pkg;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int LEVEL_WIDTH     = 15;
    localparam int WEIGHT_WIDTH    = 16;
    localparam int FRAC_BITS       = 16;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_FILTER_ENABLE    = 2'd0,
        REG_CLIP_LEVEL       = 2'd1,
        REG_SMOOTHING_WEIGHT = 2'd2,
        REG_JUMP_LIMIT       = 2'd3
    } cfg_index_t;

    // Floors and cap applied to the raw register values.
    localparam logic [LEVEL_WIDTH-1:0]  CLIP_FLOOR = 15'd256;
    localparam logic [LEVEL_WIDTH-1:0]  JUMP_FLOOR = 15'd256;
    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_CAP = 16'd62259;

    // Reset values: enabled, 8.0, 0.20, 4.5.
    localparam logic                    RESET_ENABLE = 1'b1;
    localparam logic [LEVEL_WIDTH-1:0]  RESET_CLIP   = 15'd2048;
    localparam logic [WEIGHT_WIDTH-1:0] RESET_WEIGHT = 16'd13107;
    localparam logic [LEVEL_WIDTH-1:0]  RESET_JUMP   = 15'd1152;

    // Effective settings, with floors and cap already applied.
    typedef struct packed {
        logic                    enable;
        logic [LEVEL_WIDTH-1:0]  clip;
        logic [WEIGHT_WIDTH-1:0] weight;
        logic [LEVEL_WIDTH-1:0]  jump;
    } cfg_t;

endpackage

>>> rtl/core/outlier_limited_smoothing_filter_top.sv
// Top level of the outlier limited smoothing filter.
// Instantiates osf_cfg_regs and osf_core; uses osf_pkg.
//
// Input channel: in_valid / in_stall with sample (signed Q7.8) and
// starts_vector, which restarts the history at the first item of a vector.
// Output channel: out_valid / out_stall with one filtered sample per item.
// Configuration: cfg_write, cfg_index, cfg_data; write only while idle.
//
// Each accepted item lands in an input register; the clip, jump limit and
// one-multiplier blend run from there into the result register when it is
// free, and the output is taken from the result register. The held value
// feeds back from the result step, giving one item per cycle sustained
// while out_stall stays low.
// When out_stall is high the result register holds and the input register
// fills; in_stall then rises until the result is taken.
// Reset empties both registers, clears the held value to zero and loads the
// register defaults: enabled, clip 8.0, weight 0.20, jump limit 4.5.
module outlier_limited_smoothing_filter_top #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [osf_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [osf_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample,
    input  logic                                 starts_vector,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]       filtered
);

    osf_pkg::cfg_t cfg;

    logic                           in_valid_reg;
    logic                           in_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           first_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] filtered_reg;
    logic signed [SAMPLE_WIDTH-1:0] held_reg;
    logic signed [SAMPLE_WIDTH-1:0] result;
    logic                           out_free;
    logic                           advance;
    logic                           take_in;

    osf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    osf_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_core (
        .cfg           (cfg),
        .sample        (sample_reg),
        .starts_vector (first_reg),
        .held          (held_reg),
        .filtered      (result)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign take_in  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take_in)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            // A pass-through item leaves the history alone.
            if (advance && cfg.enable)
                held_reg <= result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            sample_reg <= sample;
            first_reg  <= starts_vector;
        end
        if (advance)
            filtered_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

endmodule

>>> rtl/core/osf_cfg_regs.sv
// Configuration registers of the outlier limited smoothing filter.
// Stores effective values (floors and cap applied on write); uses osf_pkg.
module osf_cfg_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [osf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [osf_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    output osf_pkg::cfg_t                         cfg
);

    osf_pkg::cfg_t cfg_reg;
    osf_pkg::cfg_t cfg_next;

    logic [osf_pkg::LEVEL_WIDTH-1:0]  level_raw;
    logic [osf_pkg::WEIGHT_WIDTH-1:0] weight_raw;
    logic [osf_pkg::LEVEL_WIDTH-1:0]  clip_eff;
    logic [osf_pkg::LEVEL_WIDTH-1:0]  jump_eff;
    logic [osf_pkg::WEIGHT_WIDTH-1:0] weight_eff;

    assign level_raw  = cfg_data[osf_pkg::LEVEL_WIDTH-1:0];
    assign weight_raw = cfg_data[osf_pkg::WEIGHT_WIDTH-1:0];
    assign clip_eff   = (level_raw < osf_pkg::CLIP_FLOOR) ? osf_pkg::CLIP_FLOOR : level_raw;
    assign jump_eff   = (level_raw < osf_pkg::JUMP_FLOOR) ? osf_pkg::JUMP_FLOOR : level_raw;
    assign weight_eff = (weight_raw > osf_pkg::WEIGHT_CAP) ? osf_pkg::WEIGHT_CAP : weight_raw;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (osf_pkg::cfg_index_t'(cfg_index))
                osf_pkg::REG_FILTER_ENABLE:    cfg_next.enable = cfg_data[0];
                osf_pkg::REG_CLIP_LEVEL:       cfg_next.clip   = clip_eff;
                osf_pkg::REG_SMOOTHING_WEIGHT: cfg_next.weight = weight_eff;
                osf_pkg::REG_JUMP_LIMIT:       cfg_next.jump   = jump_eff;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable <= osf_pkg::RESET_ENABLE;
            cfg_reg.clip   <= osf_pkg::RESET_CLIP;
            cfg_reg.weight <= osf_pkg::RESET_WEIGHT;
            cfg_reg.jump   <= osf_pkg::RESET_JUMP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/osf_core.sv
// Filter arithmetic: clip, jump limit and weighted blend, or bypass when disabled.
// Combinational; uses osf_pkg for the settings struct.
module osf_core #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  osf_pkg::cfg_t                   cfg,
    input  logic signed [SAMPLE_WIDTH-1:0]  sample,
    input  logic                            starts_vector,
    input  logic signed [SAMPLE_WIDTH-1:0]  held,
    output logic signed [SAMPLE_WIDTH-1:0]  filtered
);

    // Wide enough for the sample and for the 15-bit levels, plus sign and margin.
    localparam int XW = ((SAMPLE_WIDTH > osf_pkg::LEVEL_WIDTH + 1) ?
                         SAMPLE_WIDTH : osf_pkg::LEVEL_WIDTH + 1) + 2;
    localparam int DW = SAMPLE_WIDTH + 1;
    localparam int PW = SAMPLE_WIDTH + osf_pkg::FRAC_BITS + 2;

    logic signed [XW-1:0] v_ext;
    logic signed [XW-1:0] held_ext;
    logic signed [XW-1:0] clip_pos;
    logic signed [XW-1:0] clip_neg;
    logic signed [XW-1:0] jump_pos;
    logic signed [XW-1:0] v_clip;
    logic signed [XW-1:0] delta;
    logic signed [XW-1:0] mag;
    logic signed [XW-1:0] v_lim;
    logic signed [DW-1:0] diff;
    logic signed [osf_pkg::WEIGHT_WIDTH:0] weight_s;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] sum;
    logic signed [PW-1:0] blend;

    assign v_ext    = XW'(sample);
    assign held_ext = XW'(held);
    assign clip_pos = $signed({{(XW-osf_pkg::LEVEL_WIDTH){1'b0}}, cfg.clip});
    assign clip_neg = -clip_pos;
    assign jump_pos = $signed({{(XW-osf_pkg::LEVEL_WIDTH){1'b0}}, cfg.jump});

    always_comb
    begin
        priority if (v_ext > clip_pos)
            v_clip = clip_pos;
        else if (v_ext < clip_neg)
            v_clip = clip_neg;
        else
            v_clip = v_ext;
    end

    assign delta = v_clip - held_ext;
    assign mag   = delta[XW-1] ? -delta : delta;

    // Limit the step toward the clipped sample; stays between held and v_clip.
    always_comb
    begin
        if (mag > jump_pos)
            v_lim = delta[XW-1] ? (held_ext - jump_pos) : (held_ext + jump_pos);
        else
            v_lim = v_clip;
    end

    // held*a + v*(1 - a) rewritten as v*1.0 + (held - v)*a: one multiplier.
    assign diff     = DW'(held_ext - v_lim);
    assign weight_s = $signed({1'b0, cfg.weight});
    assign prod     = PW'(diff) * PW'(weight_s);
    assign sum      = (PW'(v_lim) <<< osf_pkg::FRAC_BITS) + prod
                      + PW'(1 <<< (osf_pkg::FRAC_BITS - 1));
    assign blend    = sum >>> osf_pkg::FRAC_BITS;

    always_comb
    begin
        priority if (!cfg.enable)
            filtered = sample;
        else if (starts_vector)
            filtered = v_clip[SAMPLE_WIDTH-1:0];
        else
            filtered = blend[SAMPLE_WIDTH-1:0];
    end

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for outlier_limited_smoothing_filter_top: directed and random
// items, predicted by a local copy of the clip, jump limit and blend recurrence.
// Depends on osf_pkg and the RTL under rtl/core only.
module testbench;

    localparam int SW          = 16;
    localparam int RESET_CYC   = 6;
    localparam int SETTLE_CYC  = 4;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 178;
    localparam longint ONE_Q16  = 65536;
    localparam longint HALF_Q16 = 32768;
    localparam longint SMAX     = 32767;
    localparam longint SMIN     = -32768;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 cfg_write;
    osf_pkg::cfg_index_t                  cfg_index;
    logic [osf_pkg::CFG_DATA_WIDTH-1:0]   cfg_data;
    logic                                 in_valid;
    logic                                 in_stall;
    logic signed [SW-1:0]                 sample;
    logic                                 starts_vector;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic signed [SW-1:0]                 filtered;

    // Local copy of the register file and the held value
    logic                                 cfg_enable;
    logic [osf_pkg::LEVEL_WIDTH-1:0]      cfg_clip;
    logic [osf_pkg::WEIGHT_WIDTH-1:0]     cfg_weight;
    logic [osf_pkg::LEVEL_WIDTH-1:0]      cfg_jump;
    logic signed [SW-1:0]                 last_filtered;

    logic signed [SW-1:0]        filtered_due[$];
    int                          mismatches = 0;
    int                          results_seen = 0;
    int                          cycle_count = 0;

    bit                          tx_idling = 1'b1;
    bit                          rx_idling = 1'b1;
    int                          hold_len = 0;
    int                          hold_trig = 0;

    outlier_limited_smoothing_filter_top #(.SAMPLE_WIDTH(SW)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .starts_vector (starts_vector),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .filtered      (filtered)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
                     filtered_due.size());
            $display("** outlier_limited_smoothing_filter_top: FAILED **");
            $finish;
        end
    end

    function automatic longint eff_clip();
        return (cfg_clip < osf_pkg::CLIP_FLOOR) ? longint'(osf_pkg::CLIP_FLOOR)
                                                : longint'(cfg_clip);
    endfunction

    function automatic longint eff_jump();
        return (cfg_jump < osf_pkg::JUMP_FLOOR) ? longint'(osf_pkg::JUMP_FLOOR)
                                                : longint'(cfg_jump);
    endfunction

    // Clip, limit the jump, blend unless first; when enabled this is the new held value.
    function automatic logic signed [SW-1:0] smooth_step(logic signed [SW-1:0] x, logic first);
        longint v, clip, th, a, delta, mag, acc, res;
        if (!cfg_enable)
            return x;
        clip = eff_clip();
        th   = eff_jump();
        a    = (cfg_weight > osf_pkg::WEIGHT_CAP) ? longint'(osf_pkg::WEIGHT_CAP)
                                                  : longint'(cfg_weight);
        v    = longint'(x);
        if (v > clip)
            v = clip;
        else if (v < -clip)
            v = -clip;
        if (first)
            res = v;
        else
        begin
            delta = v - longint'(last_filtered);
            mag   = (delta < 0) ? -delta : delta;
            if (mag > th)
                v = longint'(last_filtered) + ((delta > 0) ? th : -th);
            acc = longint'(last_filtered) * a + v * (ONE_Q16 - a) + HALF_Q16;
            res = acc >>> 16;
        end
        if (res > SMAX)
            res = SMAX;
        else if (res < SMIN)
            res = SMIN;
        last_filtered = res[SW-1:0];
        return res[SW-1:0];
    endfunction

    task automatic flag_mismatch(string what, logic signed [SW-1:0] got,
                                 logic signed [SW-1:0] want);
        $display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    // Compare each taken item with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (filtered_due.size() == 0)
                flag_mismatch("unexpected item, filtered", filtered, 'x);
            else if (filtered !== filtered_due[0])
                flag_mismatch("filtered", filtered, filtered_due.pop_front());
            else
                void'(filtered_due.pop_front());
            results_seen++;
        end
    end

    // Receiver: alternate flow/stall runs, or flow if not idling; a hold-off wins.
    int  hold_ack = 0;
    int  hold_left = 0;
    int  run_left = 0;
    bit  run_stall = 1'b0;
    always @(posedge clk)
    begin
        if (hold_trig != hold_ack)
        begin
            hold_ack  = hold_trig;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!rx_idling)
            out_stall <= 1'b0;
        else if (run_left > 0)
        begin
            run_left--;
            out_stall <= run_stall;
        end
        else
        begin
            run_stall = !run_stall;
            if (run_stall)
                run_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
            else
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 8);
            out_stall <= run_stall;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!tx_idling || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one item, wait for it to be taken, then record its prediction.
    task automatic send_item(logic signed [SW-1:0] x, logic first);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        sample        <= x;
        starts_vector <= first;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        filtered_due.push_back(smooth_step(x, first));
    endtask

    // Drop valid and let every predicted item come out before going on.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (filtered_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic apply_settings(logic [15:0] en_d, logic [15:0] clip_d,
                                  logic [15:0] weight_d, logic [15:0] jump_d);
        cfg_write <= 1'b1;
        cfg_index <= osf_pkg::REG_FILTER_ENABLE;
        cfg_data  <= en_d;
        @(posedge clk);
        cfg_index <= osf_pkg::REG_CLIP_LEVEL;
        cfg_data  <= clip_d;
        @(posedge clk);
        cfg_index <= osf_pkg::REG_SMOOTHING_WEIGHT;
        cfg_data  <= weight_d;
        @(posedge clk);
        cfg_index <= osf_pkg::REG_JUMP_LIMIT;
        cfg_data  <= jump_d;
        @(posedge clk);
        cfg_write  <= 1'b0;
        cfg_enable = en_d[0];
        cfg_clip   = clip_d[osf_pkg::LEVEL_WIDTH-1:0];
        cfg_weight = weight_d;
        cfg_jump   = jump_d[osf_pkg::LEVEL_WIDTH-1:0];
    endtask

    function automatic logic [15:0] pick_level();
        unique case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'($urandom_range(0, 255));
            2:       return 16'd256;
            3:       return 16'h7FFF;
            4:       return 16'hFFFF;
            5:       return 16'($urandom);
            default: return 16'($urandom_range(200, 3000));
        endcase
    endfunction

    function automatic logic [15:0] pick_weight();
        unique case ($urandom_range(0, 6))
            0:       return 16'd0;
            1:       return osf_pkg::WEIGHT_CAP;
            2:       return osf_pkg::WEIGHT_CAP + 16'd1;
            3:       return 16'hFFFF;
            4:       return 16'($urandom);
            default: return 16'($urandom_range(0, 62259));
        endcase
    endfunction

    // Mix of full range, extremes, clip edges and steps around the held value.
    function automatic logic signed [SW-1:0] random_sample();
        longint b, span;
        unique case ($urandom_range(0, 9))
            0, 1, 2: return SW'($urandom);
            3:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            4:
            begin
                b = eff_clip() + $urandom_range(0, 1);
                return SW'($urandom_range(0, 1) ? b : -b);
            end
            5, 6:
            begin
                span = $urandom_range(1, 600);
                return SW'(longint'(last_filtered) + longint'($urandom_range(0, 2 * span))
                           - span);
            end
            7:
            begin
                b = eff_jump() + longint'($urandom_range(0, 2)) - 1;
                return SW'(longint'(last_filtered) + ($urandom_range(0, 1) ? b : -b));
            end
            default: return SW'(longint'($urandom_range(0, 1023)) - 512);
        endcase
    endfunction

    // Reset values: held value zero, no vector start on the first item.
    task automatic test_reset_defaults();
        send_item(16'sd0, 1'b0);
        send_item(16'sh7FFF, 1'b0);
        send_item(16'sh8000, 1'b0);
        send_item(16'sh8000, 1'b1);
        send_item(16'sh7FFF, 1'b1);
        send_item(SW'(longint'(last_filtered) + eff_jump()), 1'b0);
        send_item(SW'(longint'(last_filtered) - eff_jump()), 1'b0);
        send_item(SW'(longint'(last_filtered) + eff_jump() + 1), 1'b0);
        send_item(SW'(longint'(last_filtered) - eff_jump() - 1), 1'b0);
        send_item(16'sh0100, 1'b1);
        send_item(-16'sd1, 1'b0);
        send_item(16'sd1, 1'b0);
    endtask

    task automatic test_register_extremes();
        wait_idle();
        // floors and cap; upper data bits must be masked off
        apply_settings(16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000);
        send_item(16'sh7FFF, 1'b1);
        send_item(16'sh8000, 1'b0);
        send_item(16'sh8000, 1'b0);
        wait_idle();
        // disabled: pass through, held value untouched
        apply_settings(16'hFFFE, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_item(16'sh7FFF, 1'b0);
        send_item(16'sh8000, 1'b1);
        send_item(16'sd0, 1'b0);
        wait_idle();
        // re-enabled without a vector start: history from before the bypass
        apply_settings(16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_item(16'sh7FFF, 1'b0);
        send_item(16'sh8000, 1'b0);
        send_item(16'sh7FFF, 1'b1);
        wait_idle();
        apply_settings(16'h0003, 16'h7FFF, osf_pkg::WEIGHT_CAP + 16'd1, 16'd256);
        send_item(16'sh8000, 1'b0);
        send_item(16'sh7FFF, 1'b0);
        send_item(16'sh7FFF, 1'b0);
        send_item(16'sd0, 1'b1);
    endtask

    task automatic test_random_phases();
        int phase, count, len, k;
        logic [15:0] en_d;
        logic sv;
        for (phase = 0; phase < 8; phase++)
        begin
            wait_idle();
            en_d    = 16'($urandom);
            en_d[0] = ($urandom_range(0, 3) != 0);
            if (phase == 0)
                apply_settings(16'h0001, 16'h0000, 16'h0000, 16'h0000);
            else if (phase == 1)
                apply_settings(16'h0001, 16'h7FFF, 16'hFFFF, 16'h7FFF);
            else
                apply_settings(en_d, pick_level(), pick_weight(), pick_level());
            tx_idling = (phase != 3);
            rx_idling = (phase != 3);
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                   : $urandom_range(1, 12);
                for (k = 0; k < len && count < PHASE_ITEMS; k++)
                begin
                    sv = (k == 0);
                    // broken vectors now and then
                    if ($urandom_range(0, 9) == 0)
                        sv = 1'($urandom_range(0, 1));
                    send_item(random_sample(), sv);
                    count++;
                end
            end
        end
        tx_idling = 1'b1;
        rx_idling = 1'b1;
    endtask

    // Hold the receiver off while items keep coming, then pause the sender mid-stream.
    task automatic test_backpressure();
        int k;
        wait_idle();
        apply_settings(16'h0001, pick_level(), pick_weight(), pick_level());
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        hold_len  = 80;
        hold_trig++;
        for (k = 0; k < 40; k++)
            send_item(random_sample(), (k % 8) == 0);
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        for (k = 0; k < 60; k++)
        begin
            if (k == 30)
                wait_idle();
            send_item(random_sample(), (k % 10) == 0);
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= osf_pkg::REG_FILTER_ENABLE;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        sample        <= '0;
        starts_vector <= 1'b0;
        cfg_enable    = osf_pkg::RESET_ENABLE;
        cfg_clip      = osf_pkg::RESET_CLIP;
        cfg_weight    = osf_pkg::RESET_WEIGHT;
        cfg_jump      = osf_pkg::RESET_JUMP;
        last_filtered = '0;
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_phases();
        test_backpressure();

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("** outlier_limited_smoothing_filter_top: PASSED **");
        else
            $display("** outlier_limited_smoothing_filter_top: FAILED **");
        $finish;
    end

endmodule
